// File: sv/pwl_pkg.sv
// Shared types and constants for the piecewise-linear curve lookup.
`default_nettype none

package pwl_pkg;

  // Fixed field widths of the command, slot and register ports.
  localparam int CMD_W    = 2;
  localparam int IDX_IN_W = 4;
  localparam int CFG_W    = 5;

  // Command codes carried on the input tuser; the fourth code writes nothing and answers 0.
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_FWD  = 2'd1,
    CMD_INV  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_RES
  } state_e;

endpackage

`default_nettype wire

// File: sv/piecewise_linear_curve_lookup.sv
// Piecewise-linear curve lookup: breakpoint table, segment walk, serial multiply/divide.
`default_nettype none

// Holds up to MAX_POINTS (x, y) breakpoints and answers forward (x to y) and
// inverse (y to x) queries by linear interpolation over the first
// points_in_use slots. Each input transfer carries one command: a load writes
// one slot and answers 0; a query answers the interpolated value, saturated to
// the signed VALUE_BITS range, with the miss flag set when the table is empty
// or an inverse query lies on no segment. The product of the two differences
// is formed before the division, and the quotient truncates toward zero.
// One item is in work at a time. A load, an unknown command or a query on a
// table too small to search goes straight to the result register. Any other
// query first walks 1 to points_in_use slots, and an interpolating one then
// runs through multiplier and divider: the table sits in a one-read-port
// memory visited one slot per cycle, the product comes out of a bit-serial
// shift-add multiplier (one bit per cycle) and the quotient out of a restoring
// divider (one bit per cycle). A result waits in the result register until
// the output register is free. The next item is taken in the cycle after the
// output register is loaded. A finished result waits in the output register
// while the next item is taken in. Slots that were never loaded hold unknown
// data; queries must not reach them. points_in_use above MAX_POINTS counts as
// MAX_POINTS, and loads to slots beyond it are dropped.
module piecewise_linear_curve_lookup #(
  parameter int MAX_POINTS = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata, low bit up: point_index, point_x, point_y, query_value, zero pad
  input  wire logic [((pwl_pkg::IDX_IN_W + 3 * VALUE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: cmd
  input  wire logic [pwl_pkg::CMD_W-1:0] s_axis_tuser,
  // Result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata, low bit up: result_value, zero pad
  output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: miss
  output logic                       m_axis_tuser,
  // Register write channel: points_in_use
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [pwl_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int VB       = VALUE_BITS;
  localparam int DW       = VB + 1;          // difference of two values
  localparam int PW       = 2 * VB + 1;      // product / dividend shift register
  localparam int SW       = 2 * VB + 2;      // signed final sum
  localparam int IDX_W    = $clog2(MAX_POINTS);
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int STEP_W   = $clog2(2 * VB);
  localparam int M_DATA_W = ((VB + 7) / 8) * 8;

  // ---------------------------------------------------------------------
  // Input field unpacking
  // ---------------------------------------------------------------------
  logic [pwl_pkg::IDX_IN_W-1:0] in_index;
  logic [VB-1:0]                in_px;
  logic [VB-1:0]                in_py;
  logic signed [VB-1:0]         in_query;

  assign in_index = s_axis_tdata[pwl_pkg::IDX_IN_W-1:0];
  assign in_px    = s_axis_tdata[pwl_pkg::IDX_IN_W +: VB];
  assign in_py    = s_axis_tdata[pwl_pkg::IDX_IN_W + VB +: VB];
  assign in_query = s_axis_tdata[pwl_pkg::IDX_IN_W + 2 * VB +: VB];

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  pwl_pkg::state_e state_q, state_d;

  logic [pwl_pkg::CFG_W-1:0] points_q;
  logic                      m_valid_q;
  logic [STEP_W-1:0]         step_q, step_d;
  logic [IDX_W-1:0]          cur_idx_q;
  logic                      first_q;

  logic                      fwd_q;
  logic signed [VB-1:0]      q_q;
  logic [2*VB-1:0]           rdata_q;
  logic [2*VB-1:0]           prev_q;
  logic [VB-1:0]             mag_a_q;
  logic [VB-1:0]             mag_d_q;
  logic                      neg_q;
  logic signed [VB-1:0]      base_q;
  logic [PW-1:0]             prod_q, prod_d;
  logic [VB-1:0]             rem_q, rem_d;
  logic [VB-1:0]             res_q;
  logic                      miss_q;
  logic [VB-1:0]             out_val_q;
  logic                      out_miss_q;

  // Breakpoint memory, one {y, x} word per slot
  logic [2*VB-1:0]           mem_q [MAX_POINTS];

  // ---------------------------------------------------------------------
  // Table size in use
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] n_use;
  logic             walk_last;

  assign n_use = (32'(points_q) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : CNT_W'(points_q);
  assign walk_last = (CNT_W'(cur_idx_q) + CNT_W'(1)) == n_use;

  // ---------------------------------------------------------------------
  // Segment compare and operand setup
  // ---------------------------------------------------------------------
  logic signed [VB-1:0] cur_x, cur_y, prev_x, prev_y, lo_y, hi_y;
  logic signed [DW-1:0] dx, dy, qx, qy, op_a, op_b, op_d;
  logic                 fwd_hit, inv_hit, dx_pos;

  assign cur_x  = rdata_q[VB-1:0];
  assign cur_y  = rdata_q[2*VB-1:VB];
  assign prev_x = prev_q[VB-1:0];
  assign prev_y = prev_q[2*VB-1:VB];

  assign dx = DW'(cur_x) - DW'(prev_x);
  assign dy = DW'(cur_y) - DW'(prev_y);
  assign qx = DW'(q_q) - DW'(prev_x);
  assign qy = DW'(q_q) - DW'(prev_y);

  assign lo_y = (prev_y < cur_y) ? prev_y : cur_y;
  assign hi_y = (prev_y < cur_y) ? cur_y : prev_y;

  assign fwd_hit = q_q < cur_x;
  assign inv_hit = (lo_y <= q_q) && (q_q < hi_y);
  assign dx_pos  = !dx[DW-1] && (dx != '0);

  // forward: (y1-y0)*(q-x0)/(x1-x0); inverse: (q-y0)*(x1-x0)/(y1-y0)
  assign op_a = fwd_q ? dy : qy;
  assign op_b = fwd_q ? qx : dx;
  assign op_d = fwd_q ? dx : dy;

  logic [DW-1:0] abs_a, abs_b, abs_d;
  assign abs_a = op_a[DW-1] ? DW'(-op_a) : DW'(op_a);
  assign abs_b = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
  assign abs_d = op_d[DW-1] ? DW'(-op_d) : DW'(op_d);

  // ---------------------------------------------------------------------
  // Serial multiply step (shift-add, multiplier bits leave at the bottom)
  // ---------------------------------------------------------------------
  logic [DW-1:0] mul_sum;
  assign mul_sum = prod_q[PW-1:VB] + (prod_q[0] ? DW'(mag_a_q) : DW'(0));

  // Serial divide step (restoring, dividend bits leave at the top)
  logic [DW-1:0] rem_sh, rem_sub;
  logic          div_ge;
  assign rem_sh  = {rem_q, prod_q[2*VB-1]};
  assign div_ge  = rem_sh >= DW'(mag_d_q);
  assign rem_sub = rem_sh - DW'(mag_d_q);

  logic mul_last, div_last;
  assign mul_last = step_q == STEP_W'(VB - 1);
  assign div_last = step_q == STEP_W'(2 * VB - 1);

  // ---------------------------------------------------------------------
  // Signed add of base and quotient, then saturation
  // ---------------------------------------------------------------------
  logic signed [SW-1:0] quot_s, sum_s;
  logic [SW-VB:0]       sum_top;
  logic [VB-1:0]        sat_val;

  assign quot_s  = SW'(prod_q[2*VB-1:0]);
  assign sum_s   = (neg_q ? -quot_s : quot_s) + SW'(base_q);
  assign sum_top = sum_s[SW-1:VB-1];
  assign sat_val = ((&sum_top) || !(|sum_top)) ? sum_s[VB-1:0]
                 : (sum_s[SW-1] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}});

  // ---------------------------------------------------------------------
  // Control outputs
  // ---------------------------------------------------------------------
  logic          s_ready, in_acc, out_free;
  logic          wr_en, start_walk, imm_en, imm_miss, walk_adv, go_arith, push;
  logic [VB-1:0] imm_val;
  logic          idx_ok;

  assign in_acc   = s_axis_tvalid && s_ready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign idx_ok   = 32'(in_index) < MAX_POINTS;

  always_comb begin
    s_ready    = 1'b0;
    wr_en      = 1'b0;
    start_walk = 1'b0;
    imm_en     = 1'b0;
    imm_miss   = 1'b0;
    imm_val    = '0;
    walk_adv   = 1'b0;
    go_arith   = 1'b0;
    push       = 1'b0;
    unique case (state_q)
      pwl_pkg::ST_IDLE: begin
        s_ready = 1'b1;
        if (s_axis_tvalid) begin
          unique case (s_axis_tuser)
            pwl_pkg::CMD_LOAD: begin
              wr_en  = idx_ok;
              imm_en = 1'b1;
            end
            pwl_pkg::CMD_FWD: begin
              if (n_use == '0) begin
                imm_en   = 1'b1;
                imm_miss = 1'b1;
              end else begin
                start_walk = 1'b1;
              end
            end
            pwl_pkg::CMD_INV: begin
              if (n_use < CNT_W'(2)) begin
                imm_en   = 1'b1;
                imm_miss = 1'b1;
              end else begin
                start_walk = 1'b1;
              end
            end
            default: imm_en = 1'b1;
          endcase
        end
      end
      pwl_pkg::ST_WALK: begin
        if (first_q) begin
          // slot 0: clamp below the first x, or a one-point table
          if (fwd_q && (fwd_hit || walk_last)) begin
            imm_en  = 1'b1;
            imm_val = cur_y;
          end else begin
            walk_adv = 1'b1;
          end
        end else if (fwd_q ? fwd_hit : inv_hit) begin
          if (fwd_q && !dx_pos) begin
            imm_en  = 1'b1;
            imm_val = prev_y;
          end else begin
            go_arith = 1'b1;
          end
        end else if (walk_last) begin
          imm_en   = 1'b1;
          imm_val  = fwd_q ? cur_y : '0;
          imm_miss = !fwd_q;
        end else begin
          walk_adv = 1'b1;
        end
      end
      pwl_pkg::ST_MUL,
      pwl_pkg::ST_DIV,
      pwl_pkg::ST_FIN: ;
      pwl_pkg::ST_RES: push = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwl_pkg::ST_IDLE: begin
        if (s_axis_tvalid) state_d = start_walk ? pwl_pkg::ST_WALK : pwl_pkg::ST_RES;
      end
      pwl_pkg::ST_WALK: begin
        if (go_arith)    state_d = pwl_pkg::ST_MUL;
        else if (imm_en) state_d = pwl_pkg::ST_RES;
      end
      pwl_pkg::ST_MUL: if (mul_last) state_d = pwl_pkg::ST_DIV;
      pwl_pkg::ST_DIV: if (div_last) state_d = pwl_pkg::ST_FIN;
      pwl_pkg::ST_FIN: state_d = pwl_pkg::ST_RES;
      pwl_pkg::ST_RES: if (push) state_d = pwl_pkg::ST_IDLE;
      default: state_d = pwl_pkg::ST_IDLE;
    endcase
  end

  // step counter: multiply bits, then restart for the quotient bits
  always_comb begin
    step_d = step_q;
    if (go_arith) begin
      step_d = '0;
    end else if (state_q == pwl_pkg::ST_MUL) begin
      step_d = mul_last ? '0 : step_q + STEP_W'(1);
    end else if (state_q == pwl_pkg::ST_DIV) begin
      step_d = step_q + STEP_W'(1);
    end
  end

  // product register: load multiplier, shift-add, then divide in place
  always_comb begin
    prod_d = prod_q;
    rem_d  = rem_q;
    if (go_arith) begin
      prod_d = PW'(abs_b[VB-1:0]);
      rem_d  = '0;
    end else if (state_q == pwl_pkg::ST_MUL) begin
      prod_d = {1'b0, mul_sum, prod_q[VB-1:1]};
    end else if (state_q == pwl_pkg::ST_DIV) begin
      prod_d = {1'b0, prod_q[2*VB-2:0], div_ge};
      rem_d  = div_ge ? rem_sub[VB-1:0] : rem_sh[VB-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pwl_pkg::ST_IDLE;
      points_q  <= '0;
      m_valid_q <= 1'b0;
      step_q    <= '0;
      cur_idx_q <= '0;
      first_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_valid_i) points_q <= cfg_data_i;
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (start_walk) begin
        cur_idx_q <= '0;
        first_q   <= 1'b1;
      end else if (walk_adv) begin
        cur_idx_q <= cur_idx_q + IDX_W'(1);
        first_q   <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Breakpoint memory: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] rd_addr;
  assign rd_addr = (state_q == pwl_pkg::ST_IDLE) ? '0 : cur_idx_q + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[IDX_W'(in_index)] <= {in_py, in_px};
    rdata_q <= mem_q[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    if (in_acc) begin
      fwd_q <= s_axis_tuser == pwl_pkg::CMD_FWD;
      q_q   <= in_query;
    end
    if (walk_adv) prev_q <= rdata_q;
    if (go_arith) begin
      mag_a_q <= abs_a[VB-1:0];
      mag_d_q <= abs_d[VB-1:0];
      neg_q   <= op_a[DW-1] ^ op_b[DW-1] ^ op_d[DW-1];
      base_q  <= fwd_q ? prev_y : prev_x;
    end
    if (imm_en) begin
      res_q  <= imm_val;
      miss_q <= imm_miss;
    end else if (state_q == pwl_pkg::ST_FIN) begin
      res_q  <= sat_val;
      miss_q <= 1'b0;
    end
    if (push) begin
      out_val_q  <= res_q;
      out_miss_q <= miss_q;
    end
  end

  // ---------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------
  assign s_axis_tready = s_ready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_DATA_W'(out_val_q);
  assign m_axis_tuser  = out_miss_q;
  assign cfg_ready_o   = 1'b1;

`ifndef NO_ASSERTIONS
  // a miss always comes with a zero answer
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss transfer with nonzero result");

  // restoring divider keeps its remainder below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pwl_pkg::ST_DIV) |-> (rem_q < mag_d_q))
    else $error("divider remainder out of range");

  // arithmetic only starts on a segment of nonzero span
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pwl_pkg::ST_MUL || state_q == pwl_pkg::ST_DIV) |-> (mag_d_q != '0))
    else $error("zero divisor in arithmetic");

  // the walk never reads beyond the slots in use
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pwl_pkg::ST_WALK) |-> (CNT_W'(cur_idx_q) < n_use))
    else $error("segment walk past table end");
`endif

endmodule

`default_nettype wire
